[sv/assert_macros.svh]
// Assertion macros for the RTL of the string unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk, held off while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/jsu_pkg.sv]
// Package of types, codes and helper functions for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned ResCntW = 3;

  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;
  localparam logic [7:0]  Utf8Mask  = 8'h3F;
  localparam logic [15:0] Utf8Lim1  = 16'h0080;
  localparam logic [15:0] Utf8Lim2  = 16'h0800;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeStr  = 2'd1,
    ModeEsc  = 2'd2,
    ModeHex  = 2'd3
  } scan_mode_e;

  typedef enum logic [KindW-1:0] {
    KindData  = 2'd0,
    KindClose = 2'd1,
    KindEos   = 2'd2,
    KindNoq   = 2'd3
  } kind_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0] cnt;   // 1 to 3 bytes
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } utf8_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_enc(input logic [15:0] v);
    utf8_t u;
    u.cnt = 2'd1;
    u.b0  = v[7:0];
    u.b1  = 8'h00;
    u.b2  = 8'h00;
    if (v < Utf8Lim1) begin
      u.cnt = 2'd1;
    end else if (v < Utf8Lim2) begin
      u.cnt = 2'd2;
      u.b0  = Utf8Lead2 | {3'b000, v[10:6]};
      u.b1  = Utf8Cont | ({2'b00, v[5:0]} & Utf8Mask);
    end else begin
      u.cnt = 2'd3;
      u.b0  = Utf8Lead3 | {4'b0000, v[15:12]};
      u.b1  = Utf8Cont | ({2'b00, v[11:6]} & Utf8Mask);
      u.b2  = Utf8Cont | ({2'b00, v[5:0]} & Utf8Mask);
    end
    return u;
  endfunction

endpackage

`default_nettype wire

[sv/json_string_unescaper.sv]
// Top level of the JSON string unescaper: byte scanner and result serialiser.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid_i/s_axis_tready_o tdata[7:0] in_byte
//  m_axis   out  m_axis_tvalid_o/m_axis_tready_i tdata[7:0] out_byte,
//                                                tuser[1:0] out_kind, tlast last
//
// One source byte is taken per cycle when it gives at most one result item.
// A \u escape may give up to four items; those drain one per cycle from the
// result buffer, so the input waits until the final item leaves.
// The buffer is refilled in the cycle its final item leaves; a stall on the
// output holds the buffer and the input. Reset clears the scanner to idle
// and empties the buffer.
`default_nettype none
`include "assert_macros.svh"

module json_string_unescaper (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output      logic                       s_axis_tready_o,
  input  wire logic [7:0]                 s_axis_tdata_i,   // [7:0] in_byte
  output      logic                       m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output      logic [7:0]                 m_axis_tdata_o,   // [7:0] out_byte
  output      logic [jsu_pkg::KindW-1:0]  m_axis_tuser_o,   // [1:0] out_kind
  output      logic                       m_axis_tlast_o
);
  import jsu_pkg::*;

  // scanner state
  scan_mode_e  mode_q, mode_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [15:0] hval_q, hval_d;
  logic        hstop_q, hstop_d;

  // result buffer
  logic [7:0]         byte_q [MaxRes];
  kind_e              kind_q [MaxRes];
  logic [ResCntW-1:0] rem_q;
  logic [1:0]         idx_q;

  logic [7:0]         res_byte [MaxRes];
  kind_e              res_kind [MaxRes];
  logic [ResCntW-1:0] res_n;

  logic        in_fire, out_fire;
  logic [7:0]  c;
  hex_t        hd;
  logic [15:0] hval_new;
  logic        hstop_new;
  logic [15:0] enc_val;
  utf8_t       enc;

  assign c        = s_axis_tdata_i;
  assign out_fire = m_axis_tvalid_o & m_axis_tready_i;
  // take a byte when the buffer is empty or its final item leaves now
  assign s_axis_tready_o = (rem_q == '0) ||
                           (rem_q == ResCntW'(1) && m_axis_tready_i);
  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;

  // hex digit run: a non-hex character stops accumulation for good
  assign hd        = hex_digit(c);
  assign hval_new  = (!hstop_q && hd.ok) ? {hval_q[11:0], hd.val} : hval_q;
  assign hstop_new = hstop_q | ~hd.ok;
  assign enc_val   = (c == ChNul) ? hval_q : hval_new;
  assign enc       = utf8_enc(enc_val);

  // next state
  always_comb begin
    mode_d  = mode_q;
    hcnt_d  = hcnt_q;
    hval_d  = hval_q;
    hstop_d = hstop_q;
    if (in_fire) begin
      unique case (mode_q)
        ModeIdle: begin
          if (c == ChQuote) mode_d = ModeStr;
        end
        ModeStr: begin
          if (c == ChQuote || c == ChNul) mode_d = ModeIdle;
          else if (c == ChBslash)         mode_d = ModeEsc;
        end
        ModeEsc: begin
          if (c == ChNul) begin
            mode_d = ModeIdle;
          end else if (c == ChU) begin
            mode_d  = ModeHex;
            hcnt_d  = 2'd0;
            hval_d  = 16'd0;
            hstop_d = 1'b0;
          end else begin
            mode_d = ModeStr;
          end
        end
        ModeHex: begin
          if (c == ChNul) begin
            mode_d = ModeIdle;
            hcnt_d = 2'd0;
          end else begin
            hval_d  = hval_new;
            hstop_d = hstop_new;
            if (hcnt_q == 2'd3) begin
              hcnt_d = 2'd0;
              mode_d = ModeStr;
            end else begin
              hcnt_d = hcnt_q + 2'd1;
            end
          end
        end
        default: mode_d = ModeIdle;
      endcase
    end
  end

  // result items caused by the current byte
  always_comb begin
    res_n = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res_byte[i] = 8'h00;
      res_kind[i] = KindData;
    end
    unique case (mode_q)
      ModeIdle: begin
        if (!(c == ChSpace || (c >= ChTab && c <= ChCr)) && c != ChQuote) begin
          res_n       = ResCntW'(1);
          res_kind[0] = KindNoq;
        end
      end
      ModeStr: begin
        if (c == ChQuote) begin
          res_n       = ResCntW'(1);
          res_kind[0] = KindClose;
        end else if (c == ChNul) begin
          res_n       = ResCntW'(1);
          res_kind[0] = KindEos;
        end else if (c != ChBslash) begin
          res_n       = ResCntW'(1);
          res_byte[0] = c;
        end
      end
      ModeEsc: begin
        if (c != ChU) begin
          res_n = ResCntW'(1);
          case (c)
            ChNul:   res_kind[0] = KindEos;
            ChB:     res_byte[0] = 8'h08;
            ChF:     res_byte[0] = 8'h0C;
            ChN:     res_byte[0] = 8'h0A;
            ChR:     res_byte[0] = 8'h0D;
            ChT:     res_byte[0] = 8'h09;
            default: res_byte[0] = c;
          endcase
        end
      end
      ModeHex: begin
        if (c == ChNul || hcnt_q == 2'd3) begin
          res_byte[0] = enc.b0;
          res_byte[1] = enc.b1;
          res_byte[2] = enc.b2;
          res_n       = {1'b0, enc.cnt};
          if (c == ChNul) begin
            // zero byte: the code point so far, then the unterminated mark
            res_byte[enc.cnt] = 8'h00;
            res_kind[enc.cnt] = KindEos;
            res_n             = {1'b0, enc.cnt} + ResCntW'(1);
          end
        end
      end
      default: res_n = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      hcnt_q  <= 2'd0;
      hval_q  <= 16'd0;
      hstop_q <= 1'b0;
      rem_q   <= '0;
      idx_q   <= 2'd0;
    end else begin
      mode_q  <= mode_d;
      hcnt_q  <= hcnt_d;
      hval_q  <= hval_d;
      hstop_q <= hstop_d;
      if (in_fire && res_n != '0) begin
        rem_q <= res_n;
        idx_q <= 2'd0;
      end else if (out_fire) begin
        rem_q <= rem_q - ResCntW'(1);
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // buffer payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && res_n != '0) begin
      for (int i = 0; i < MaxRes; i++) begin
        byte_q[i] <= res_byte[i];
        kind_q[i] <= res_kind[i];
      end
    end
  end

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = byte_q[idx_q];
  assign m_axis_tuser_o  = kind_q[idx_q];
  assign m_axis_tlast_o  = (rem_q == ResCntW'(1));

  // checks
  `ASSERT_ALWAYS(a_rem_bound, clk_i, !rst_ni || (({1'b0, idx_q} + rem_q) <= ResCntW'(MaxRes)), "buffer overrun")
  `ASSERT_CLK(a_in_only_near_empty, clk_i, rst_ni, s_axis_tready_o |-> rem_q <= ResCntW'(1), "input taken over a full buffer")
  `ASSERT_CLK(a_mark_is_last, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o != KindData) |-> m_axis_tlast_o, "status item not last")
  `ASSERT_CLK(a_mark_zero_byte, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o != KindData) |-> m_axis_tdata_o == 8'h00, "status item carries data")

endmodule

`default_nettype wire
